// ===== sv/bat_pkg.sv =====
// Shared constants for the adaptive threshold block: field widths, register
// indexes, reset values and request codes.
// No dependencies.
package bat_pkg;

    localparam int PIX_W   = 8;   // gray value
    localparam int COORD_W = 9;   // col / row fields
    localparam int CFG_W   = 10;  // widest config register
    localparam int DIV_W   = 6;   // window divisor register
    localparam int IDX_W   = 2;   // config register index
    localparam int INT_W   = 26;  // integral image entry
    localparam int RSUM_W  = 17;  // running row sum

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DIV_MAX        = 32;
    localparam int QUEUE_DEPTH    = 4;   // power of two

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [IDX_W-1:0] REG_WINDOW_DIVISOR = 2'd2;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 10'd512;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = 10'd512;
    localparam logic [DIV_W-1:0] RST_WINDOW_DIVISOR = 6'd8;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [PIX_W-1:0] BIN_DARK  = 8'd0;
    localparam logic [PIX_W-1:0] BIN_LIGHT = 8'd255;

endpackage

// ===== sv/bradley_adaptive_threshold_top.sv =====
// Bradley-Roth adaptive threshold over an integral image.
// Load steps in the back end: pop, read row above, write. Query steps: pop,
// four integral reads on the single read port, sum, scale, output.
// After reset and after each config write, input stalls while the window
// half size is divided out. Memories are not cleared.
module bradley_adaptive_threshold_top
    import bat_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [COORD_W-1:0] col,
    input  logic [COORD_W-1:0] row,
    input  logic [PIX_W-1:0]   pixel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [PIX_W-1:0]   bin_value,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(MAX_HEIGHT + 1);
    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int ENTRY_W = 1 + PIX_W + 3 * XW + 3 * YW;
    localparam int CLW0    = (WW > HW) ? WW : HW;
    localparam int CLW     = (CFG_W > CLW0) ? CFG_W : CLW0;

    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic [DIV_W-1:0] window_divisor_reg;

    logic [CLW-1:0]   width_ext;
    logic [CLW-1:0]   height_ext;
    logic [WW-1:0]    width_sat;
    logic [HW-1:0]    height_sat;
    logic [DIV_W-1:0] divisor_sat;

    logic               div_busy;
    logic [XW-1:0]      half_size;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic [ENTRY_W-1:0] q_data;
    logic [ENTRY_W-1:0] q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= RST_IMAGE_WIDTH;
            image_height_reg   <= RST_IMAGE_HEIGHT;
            window_divisor_reg <= RST_WINDOW_DIVISOR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:    image_width_reg    <= cfg_data;
                REG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data;
                REG_WINDOW_DIVISOR: window_divisor_reg <= DIV_W'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    // saturate registers to their usable ranges
    assign width_ext  = CLW'(image_width_reg);
    assign height_ext = CLW'(image_height_reg);

    always_comb
    begin
        if (width_ext == '0)
            width_sat = WW'(1);
        else if (width_ext > CLW'(MAX_WIDTH))
            width_sat = WW'(MAX_WIDTH);
        else
            width_sat = WW'(width_ext);

        if (height_ext == '0)
            height_sat = HW'(1);
        else if (height_ext > CLW'(MAX_HEIGHT))
            height_sat = HW'(MAX_HEIGHT);
        else
            height_sat = HW'(height_ext);

        if (window_divisor_reg == '0)
            divisor_sat = DIV_W'(1);
        else if (window_divisor_reg > DIV_W'(DIV_MAX))
            divisor_sat = DIV_W'(DIV_MAX);
        else
            divisor_sat = window_divisor_reg;
    end

    bat_div #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cfg_we),
        .width     (width_sat),
        .divisor   (divisor_sat),
        .busy      (div_busy),
        .half_size (half_size)
    );

    bat_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .col       (col),
        .row       (row),
        .pixel     (pixel),
        .width     (width_sat),
        .height    (height_sat),
        .div_busy  (div_busy),
        .half_size (half_size),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    bat_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    bat_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .bin_value (bin_value)
    );

endmodule

// ===== sv/bat_div.sv =====
// Window half-size unit: (width / divisor) / 2 by restoring division,
// one quotient bit per cycle, rerun after reset and after every config write.
// Depends on bat_pkg.
module bat_div
    import bat_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int XW = $clog2(MAX_WIDTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WW-1:0]    width,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic [XW-1:0]    half_size
);

    localparam int SW = $clog2(WW + 1);

    logic             pend_reg;
    logic             run_reg;
    logic [SW-1:0]    step_reg;
    logic [WW-1:0]    quo_reg;
    logic [WW-1:0]    quo_next;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;
    logic [XW-1:0]    s2_reg;

    assign trial    = {rem_reg, quo_reg[WW-1]};
    assign fits     = trial >= (DIV_W+1)'(divisor);
    assign diff     = trial - (DIV_W+1)'(divisor);
    assign rem_next = fits ? DIV_W'(diff) : DIV_W'(trial);
    assign quo_next = {quo_reg[WW-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b1;
            run_reg  <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            pend_reg <= 1'b1;
            run_reg  <= 1'b0;
        end
        else if (pend_reg)
        begin
            pend_reg <= 1'b0;
            run_reg  <= 1'b1;
            step_reg <= SW'(WW);
        end
        else if (run_reg)
        begin
            step_reg <= step_reg - SW'(1);
            if (step_reg == SW'(1))
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg && !start)
        begin
            quo_reg <= width;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (run_reg && !start && step_reg == SW'(1))
        begin
            s2_reg <= XW'(quo_next >> 1);
        end
    end

    assign busy      = pend_reg || run_reg;
    assign half_size = s2_reg;

    a_half_size_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> $stable(half_size))
        else $error("window half size changed while idle");

endmodule

// ===== sv/bat_queue.sv =====
// Short FIFO between the classifying front end and the memory back end.
// Depends on bat_pkg (depth).
module bat_queue
    import bat_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output logic [DATA_W-1:0] head
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW:0]       count_reg;

    assign full  = count_reg == (AW+1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + (AW+1)'(1);
                2'b01:   count_reg <= count_reg - (AW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue overflow");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");

endmodule

// ===== sv/bat_front.sv =====
// Front end: takes input transactions, drops out-of-frame ones, and for
// queries works out the clipped window corners before queueing.
// Depends on bat_pkg.
module bat_front
    import bat_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int WW      = $clog2(MAX_WIDTH + 1),
    localparam int HW      = $clog2(MAX_HEIGHT + 1),
    localparam int XW      = $clog2(MAX_WIDTH),
    localparam int YW      = $clog2(MAX_HEIGHT),
    localparam int ENTRY_W = 1 + PIX_W + 3 * XW + 3 * YW
)
(
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [COORD_W-1:0] col,
    input  logic [COORD_W-1:0] row,
    input  logic [PIX_W-1:0]   pixel,
    input  logic [WW-1:0]      width,
    input  logic [HW-1:0]      height,
    input  logic               div_busy,
    input  logic [XW-1:0]      half_size,
    input  logic               q_full,
    output logic               q_push,
    output logic [ENTRY_W-1:0] q_data
);

    localparam int KW0 = (WW > HW) ? WW : HW;
    localparam int KW  = ((KW0 > COORD_W) ? KW0 : COORD_W) + 1;

    typedef struct packed {
        logic             is_query;
        logic [YW-1:0]    row;
        logic [XW-1:0]    col;
        logic [PIX_W-1:0] pixel;
        logic [YW-1:0]    y1;
        logic [YW-1:0]    y2;
        logic [XW-1:0]    x1;
        logic [XW-1:0]    x2;
    } entry_t;

    logic [KW-1:0] col_k;
    logic [KW-1:0] row_k;
    logic [KW-1:0] w_k;
    logic [KW-1:0] h_k;
    logic [KW-1:0] s2_k;
    logic [KW-1:0] x_hi;
    logic [KW-1:0] y_hi;
    logic [KW-1:0] x_lim;
    logic [KW-1:0] y_lim;
    logic          in_frame;
    entry_t        entry;

    assign col_k = KW'(col);
    assign row_k = KW'(row);
    assign w_k   = KW'(width);
    assign h_k   = KW'(height);
    assign s2_k  = KW'(half_size);
    assign x_hi  = col_k + s2_k;
    assign y_hi  = row_k + s2_k;
    assign x_lim = w_k - KW'(1);
    assign y_lim = h_k - KW'(1);

    assign in_frame = (col_k < w_k) && (row_k < h_k);
    assign in_stall = div_busy || q_full;
    // out-of-frame transactions are taken and dropped
    assign q_push   = in_valid && !in_stall && in_frame;

    always_comb
    begin
        entry.is_query = (req_type == REQ_QUERY);
        entry.row      = YW'(row);
        entry.col      = XW'(col);
        entry.pixel    = pixel;
        entry.x1       = (col_k > s2_k) ? XW'(col_k - s2_k) : '0;
        entry.y1       = (row_k > s2_k) ? YW'(row_k - s2_k) : '0;
        entry.x2       = (x_hi > x_lim) ? XW'(x_lim) : XW'(x_hi);
        entry.y2       = (y_hi > y_lim) ? YW'(y_lim) : YW'(y_hi);
    end

    assign q_data = entry;

endmodule

// ===== sv/bat_back.sv =====
// Back end: frame and integral memories, integral build on loads, window sum
// and threshold compare on queries, output register.
// Depends on bat_pkg.
module bat_back
    import bat_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int XW      = $clog2(MAX_WIDTH),
    localparam int YW      = $clog2(MAX_HEIGHT),
    localparam int ENTRY_W = 1 + PIX_W + 3 * XW + 3 * YW
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  logic [ENTRY_W-1:0] q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [PIX_W-1:0]   bin_value
);

    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int ACC_W = INT_W + 2;
    localparam int CNT_W = XW + YW;
    localparam int LHS_W = PIX_W + CNT_W;
    localparam int CMP0  = ((LHS_W + 8) > (ACC_W + 7)) ? (LHS_W + 8) : (ACC_W + 7);
    localparam int CMP_W = CMP0 + 1;

    typedef struct packed {
        logic             is_query;
        logic [YW-1:0]    row;
        logic [XW-1:0]    col;
        logic [PIX_W-1:0] pixel;
        logic [YW-1:0]    y1;
        logic [YW-1:0]    y2;
        logic [XW-1:0]    x1;
        logic [XW-1:0]    x2;
    } entry_t;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_LD_RD   = 10'b0000000010,
        S_LD_WR   = 10'b0000000100,
        S_Q_RD0   = 10'b0000001000,
        S_Q_RD1   = 10'b0000010000,
        S_Q_RD2   = 10'b0000100000,
        S_Q_RD3   = 10'b0001000000,
        S_Q_SUM   = 10'b0010000000,
        S_Q_SCALE = 10'b0100000000,
        S_Q_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    entry_t head;
    entry_t job_reg;

    logic [PIX_W-1:0] frame_mem [DEPTH];
    logic [INT_W-1:0] int_mem [DEPTH];
    logic [PIX_W-1:0] frame_q;
    logic [INT_W-1:0] int_q;
    logic [AW-1:0]    int_raddr;
    logic [AW-1:0]    job_addr;
    logic             mem_we;
    logic [INT_W-1:0] above;
    logic [INT_W-1:0] int_wdata;

    logic [RSUM_W-1:0] rsum_reg;
    logic [RSUM_W-1:0] rsum_next;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] int_q_s;
    logic [PIX_W-1:0]        pix_reg;
    logic [XW-1:0]           dx;
    logic [YW-1:0]           dy;
    logic [CNT_W-1:0]        count_reg;
    logic [LHS_W-1:0]        lhs_reg;
    logic signed [CMP_W-1:0] lhs_inc;
    logic signed [CMP_W-1:0] acc_ext;
    logic signed [CMP_W-1:0] lhs_scaled_reg;
    logic signed [CMP_W-1:0] sum_scaled_reg;
    logic                    dark;

    logic             out_valid_reg;
    logic [PIX_W-1:0] bin_value_reg;
    logic             out_load;

    assign head     = q_head;
    assign job_addr = {job_reg.row, job_reg.col};

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        out_load   = 1'b0;
        int_raddr  = {job_reg.y2, job_reg.x2};
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = head.is_query ? S_Q_RD0 : S_LD_RD;
                end
            end
            S_LD_RD:
            begin
                // entry above; unused on the top row
                int_raddr  = {job_reg.row - YW'(1), job_reg.col};
                state_next = S_LD_WR;
            end
            S_LD_WR:
            begin
                mem_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_Q_RD0:
            begin
                int_raddr  = {job_reg.y2, job_reg.x2};
                state_next = S_Q_RD1;
            end
            S_Q_RD1:
            begin
                int_raddr  = {job_reg.y1, job_reg.x2};
                state_next = S_Q_RD2;
            end
            S_Q_RD2:
            begin
                int_raddr  = {job_reg.y2, job_reg.x1};
                state_next = S_Q_RD3;
            end
            S_Q_RD3:
            begin
                int_raddr  = {job_reg.y1, job_reg.x1};
                state_next = S_Q_SUM;
            end
            S_Q_SUM:
            begin
                state_next = S_Q_SCALE;
            end
            S_Q_SCALE:
            begin
                state_next = S_Q_OUT;
            end
            S_Q_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[job_addr] <= job_reg.pixel;
            int_mem[job_addr]   <= int_wdata;
        end
        frame_q <= frame_mem[job_addr];
        int_q   <= int_mem[int_raddr];
    end

    // ---------------- load datapath ----------------
    assign rsum_next = (job_reg.col == '0) ? RSUM_W'(job_reg.pixel)
                                           : rsum_reg + RSUM_W'(job_reg.pixel);
    assign above     = (job_reg.row == '0) ? '0 : int_q;
    assign int_wdata = INT_W'(rsum_next) + above;

    // ---------------- query datapath ----------------
    assign int_q_s = $signed(ACC_W'(int_q));
    assign dx      = job_reg.x2 - job_reg.x1;
    assign dy      = job_reg.y2 - job_reg.y1;
    assign lhs_inc = $signed(CMP_W'(lhs_reg) + CMP_W'(1));
    assign acc_ext = CMP_W'(acc_reg);
    // pixel*count < floor(sum*85/100)  <=>  100*(pixel*count + 1) <= 85*sum
    assign dark    = lhs_scaled_reg <= sum_scaled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we)
            begin
                rsum_reg <= rsum_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= head;
        end
        if (out_load)
        begin
            bin_value_reg <= dark ? BIN_DARK : BIN_LIGHT;
        end
        case (state_reg)
            S_Q_RD1:
            begin
                acc_reg   <= int_q_s;
                pix_reg   <= frame_q;
                count_reg <= CNT_W'(dx) * CNT_W'(dy);
            end
            S_Q_RD2:
            begin
                acc_reg <= acc_reg - int_q_s;
                lhs_reg <= LHS_W'(pix_reg) * LHS_W'(count_reg);
            end
            S_Q_RD3:
            begin
                acc_reg <= acc_reg - int_q_s;
            end
            S_Q_SUM:
            begin
                acc_reg <= acc_reg + int_q_s;
            end
            S_Q_SCALE:
            begin
                lhs_scaled_reg <= (lhs_inc <<< 6) + (lhs_inc <<< 5) + (lhs_inc <<< 2);
                sum_scaled_reg <= (acc_ext <<< 6) + (acc_ext <<< 4) + (acc_ext <<< 2)
                                + acc_ext;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign bin_value = bin_value_reg;

    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_Q_OUT))
        else $error("result raised outside query completion");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Q_OUT && out_valid_reg && out_stall) |=> state_reg == S_Q_OUT)
        else $error("query result overwrote a pending transaction");

endmodule

// ===== bench/tb_bradley_adaptive_threshold_top.sv =====
// Self-checking bench for bradley_adaptive_threshold_top: loads random frames,
// queries binarized pixels and checks each result against a built-in predictor.
// Depends on bat_pkg and the top-level RTL.
module tb_bradley_adaptive_threshold_top;
    import bat_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;  // no register behind it
    localparam int unsigned STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pix;
    } pixel_req_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               req_type  = REQ_LOAD;
    logic [COORD_W-1:0] col       = '0;
    logic [COORD_W-1:0] row       = '0;
    logic [PIX_W-1:0]   pixel     = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [PIX_W-1:0]   bin_value;
    logic               cfg_we    = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;

    bradley_adaptive_threshold_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .col       (col),
        .row       (row),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .bin_value (bin_value),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [CFG_W-1:0]  cfg_width   = RST_IMAGE_WIDTH;
    logic [CFG_W-1:0]  cfg_height  = RST_IMAGE_HEIGHT;
    logic [DIV_W-1:0]  cfg_divisor = RST_WINDOW_DIVISOR;
    logic [PIX_W-1:0]  pix_mem   [0:STORE_DEPTH-1];
    logic [INT_W-1:0]  integ_mem [0:STORE_DEPTH-1];
    logic [RSUM_W-1:0] row_sum = '0;

    pixel_req_t        pending_reqs[$];
    logic [PIX_W-1:0]  bin_expected[$];
    int unsigned       errors = 0;
    int unsigned       cyc = 0;
    logic              in_took = 1'b0;
    bit                hold_wanted = 1'b0;
    bit                hold_done = 1'b0;
    int unsigned       hold_left = 0;

    wire quiet = (cyc >= 3000) && (cyc < 6000);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned sat_range(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic predict_threshold(input pixel_req_t r);
        int unsigned w, h, dv, c, rw, idx, s2, x1, x2, y1, y2;
        logic [INT_W-1:0] above;
        longint cnt, win_sum, thr, lhs;
        w  = sat_range(32'(cfg_width), DEF_MAX_WIDTH);
        h  = sat_range(32'(cfg_height), DEF_MAX_HEIGHT);
        dv = sat_range(32'(cfg_divisor), DIV_MAX);
        c  = 32'(r.col);
        rw = 32'(r.row);
        if (c >= w || rw >= h)
            return;
        idx = rw * DEF_MAX_WIDTH + c;
        if (r.kind == REQ_LOAD)
        begin
            if (c == 0)
                row_sum = RSUM_W'(r.pix);
            else
                row_sum = row_sum + RSUM_W'(r.pix);
            above = (rw > 0) ? integ_mem[idx - DEF_MAX_WIDTH] : '0;
            pix_mem[idx]   = r.pix;
            integ_mem[idx] = INT_W'(row_sum) + above;
            return;
        end
        s2 = (w / dv) / 2;
        x1 = (c > s2) ? c - s2 : 0;
        y1 = (rw > s2) ? rw - s2 : 0;
        x2 = (c + s2 > w - 1) ? w - 1 : c + s2;
        y2 = (rw + s2 > h - 1) ? h - 1 : rw + s2;
        cnt = longint'(x2 - x1) * longint'(y2 - y1);
        win_sum = longint'(integ_mem[y2 * DEF_MAX_WIDTH + x2])
                - longint'(integ_mem[y1 * DEF_MAX_WIDTH + x2])
                - longint'(integ_mem[y2 * DEF_MAX_WIDTH + x1])
                + longint'(integ_mem[y1 * DEF_MAX_WIDTH + x1]);
        // threshold is floor(sum * 0.85), rounded toward minus infinity
        if (win_sum >= 0)
            thr = (win_sum * 85) / 100;
        else
            thr = -(((-win_sum) * 85 + 99) / 100);
        lhs = longint'(pix_mem[idx]) * cnt;
        bin_expected.push_back((lhs < thr) ? BIN_DARK : BIN_LIGHT);
    endtask

    // acceptance, prediction and result checking
    always @(posedge clk)
    begin
        cyc     <= cyc + 1;
        in_took <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            predict_threshold('{req_type, col, row, pixel});
        if (rst_n && out_valid && !out_stall)
        begin
            if (bin_expected.size() == 0)
            begin
                errors <= errors + 1;
                $display("%0t: unexpected bin_value, expected none, got %0d",
                         $time, bin_value);
            end
            else if (bin_value !== bin_expected[0])
            begin
                errors <= errors + 1;
                $display("%0t: bin_value mismatch, expected %0d, got %0d",
                         $time, bin_expected[0], bin_value);
                void'(bin_expected.pop_front());
            end
            else
                void'(bin_expected.pop_front());
        end
    end

    // request driver
    always @(negedge clk)
    begin : drive_requests
        pixel_req_t nxt;
        if (rst_n && (!in_valid || in_took))
        begin
            if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= 8))
            begin
                nxt = pending_reqs.pop_front();
                in_valid <= 1'b1;
                req_type <= nxt.kind;
                col      <= nxt.col;
                row      <= nxt.row;
                pixel    <= nxt.pix;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver; one long hold-off once queries are flowing
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_wanted && !hold_done && bin_expected.size() != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(99) < 8);
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_IMAGE_WIDTH:    cfg_width   = data;
            REG_IMAGE_HEIGHT:   cfg_height  = data;
            REG_WINDOW_DIVISOR: cfg_divisor = data[DIV_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned d);
        write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
        write_reg(REG_WINDOW_DIVISOR, CFG_W'(d));
    endtask

    task automatic push_req(input logic kind, input int unsigned c, input int unsigned r,
                            input int unsigned p);
        pixel_req_t t;
        t.kind = kind;
        t.col  = COORD_W'(c);
        t.row  = COORD_W'(r);
        t.pix  = PIX_W'(p);
        pending_reqs.push_back(t);
    endtask

    // a load or query that falls outside the frame
    task automatic push_noise(input int unsigned fw, input int unsigned fh);
        logic kind;
        kind = 1'($urandom_range(1));
        if (fw < DEF_MAX_WIDTH && (fh >= DEF_MAX_HEIGHT || $urandom_range(1) == 1))
            push_req(kind, $urandom_range(DEF_MAX_WIDTH - 1, fw),
                     $urandom_range(DEF_MAX_HEIGHT - 1), $urandom_range(255));
        else
            push_req(kind, $urandom_range(DEF_MAX_WIDTH - 1),
                     $urandom_range(DEF_MAX_HEIGHT - 1, fh), $urandom_range(255));
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || in_valid || bin_expected.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    initial
    begin
        int unsigned fw, fh, wreg, hreg, dreg, nq, roll, phase, frame_items;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (20) @(posedge clk);

        // 2x2 frame, divisor saturating up from zero, write to the unused index
        set_geometry(2, 2, 0);
        write_reg(REG_UNUSED, '1);
        push_req(REQ_LOAD, 0, 0, 0);
        push_req(REQ_LOAD, 1, 0, 255);
        push_req(REQ_LOAD, 511, 511, 255);
        push_req(REQ_LOAD, 0, 1, 255);
        push_req(REQ_LOAD, 1, 1, 0);
        push_req(REQ_QUERY, 2, 0, 0);
        push_req(REQ_QUERY, 0, 0, 255);
        push_req(REQ_QUERY, 1, 0, 255);
        push_req(REQ_QUERY, 0, 1, 0);
        push_req(REQ_QUERY, 1, 1, 0);
        // reload out of raster order: window sum for (0,0) goes negative
        push_req(REQ_LOAD, 1, 0, 255);
        push_req(REQ_QUERY, 0, 0, 0);
        wait_idle();

        // 1x1 frame: empty window, divisor saturating down
        set_geometry(0, 0, 63);
        push_req(REQ_LOAD, 0, 0, 200);
        push_req(REQ_QUERY, 0, 0, 17);
        push_req(REQ_QUERY, 0, 1, 0);
        wait_idle();

        phase = 0;
        frame_items = 0;
        while (frame_items < 1700)
        begin
            case (phase)
                1:
                begin
                    wreg = 1023;
                    hreg = 1;
                end
                3:
                begin
                    wreg = 1;
                    hreg = 1023;
                end
                default:
                begin
                    wreg = $urandom_range(20, 1);
                    hreg = $urandom_range(12, 1);
                end
            endcase
            case ($urandom_range(5))
                0: dreg = 0;
                1: dreg = 1;
                2: dreg = 32;
                3: dreg = 63;
                default: dreg = $urandom_range(4, 1);
            endcase
            set_geometry(wreg, hreg, dreg);
            fw = sat_range(wreg, DEF_MAX_WIDTH);
            fh = sat_range(hreg, DEF_MAX_HEIGHT);

            for (int unsigned r = 0; r < fh; r++)
                for (int unsigned c = 0; c < fw; c++)
                begin
                    if ($urandom_range(99) < 4)
                        push_noise(fw, fh);
                    push_req(REQ_LOAD, c, r, $urandom_range(255));
                end
            frame_items += fw * fh;
            if (phase == 0)
                hold_wanted = 1'b1;

            push_req(REQ_QUERY, 0, 0, $urandom_range(255));
            push_req(REQ_QUERY, fw - 1, fh - 1, $urandom_range(255));
            nq = $urandom_range(40, 20);
            repeat (nq)
            begin
                roll = $urandom_range(99);
                if (roll < 85)
                    push_req(REQ_QUERY, $urandom_range(fw - 1), $urandom_range(fh - 1),
                             $urandom_range(255));
                else if (roll < 93)
                    push_req(REQ_LOAD, $urandom_range(fw - 1), $urandom_range(fh - 1),
                             $urandom_range(255));
                else
                    push_noise(fw, fh);
            end
            frame_items += nq + 2;
            wait_idle();
            phase++;
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
sv/bat_pkg.sv
sv/bat_div.sv
sv/bat_queue.sv
sv/bat_front.sv
sv/bat_back.sv
sv/bradley_adaptive_threshold_top.sv
bench/tb_bradley_adaptive_threshold_top.sv
